// ===== hdl/i2c_temp_sensor_reader_top_defines.svh =====
// Assertion macros of the temperature sensor reader RTL.
// Included by i2ctr_core, the module that carries the concurrent checks; no other dependencies.
`ifndef I2C_TEMP_SENSOR_READER_TOP_DEFINES_SVH
`define I2C_TEMP_SENSOR_READER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check with the synchronous reset masking the property
`define I2CTR_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define I2CTR_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CTR_ASSERT_RST(lbl, clk, rst, prop, msg)
`define I2CTR_ASSERT(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/i2ctr_pkg.sv =====
// Types, constants and the bus sequence program of the temperature sensor reader.
// No dependencies; used by i2ctr_core and i2c_temp_sensor_reader_top.
package i2ctr_pkg;

   typedef logic [4:0] step_type;

   localparam step_type STEP_IDLE          = 5'd0;
   localparam step_type STEP_CONVERT_BEGIN = 5'd1;
   localparam step_type STEP_READ_BEGIN    = 5'd8;

   localparam logic [7:0] BYTE_CONVERT = 8'hEE;
   localparam logic [7:0] BYTE_READ    = 8'hAA;
   localparam logic [7:0] BYTE_RD_FLAG = 8'h01;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // register reset values
   localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
   localparam logic [7:0] ACK_WAIT_RST    = 8'd250;
   localparam logic [6:0] DEV_ADDR_RST    = 7'd72;

   // phase kinds of a program step
   typedef enum logic [5:0] {
      KIND_IDLE = 6'b000001,
      KIND_FIX  = 6'b000010,
      KIND_WLO  = 6'b000100,
      KIND_WHI  = 6'b001000,
      KIND_RLO  = 6'b010000,
      KIND_RHI  = 6'b100000
   } kind_type;

   // byte loaded when a write-bit phase begins
   typedef enum logic [1:0] {
      SEL_ADDR_W  = 2'd0,
      SEL_ADDR_R  = 2'd1,
      SEL_CONVERT = 2'd2,
      SEL_READ    = 2'd3
   } sel_type;

   // command codes on the request word
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_CONVERT = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_HALF_PERIOD = 2'd0,
      CSR_ACK_WAIT    = 2'd1,
      CSR_DEV_ADDR    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      kind_type kind;
      logic     scl;
      logic     sda;
      step_type nxt;
      sel_type  sel;
   } desc_type;

   typedef struct packed {
      logic [7:0] half_period;
      logic [7:0] ack_wait;
      logic [6:0] dev_addr;
   } cfg_type;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              busy;
      logic              done;
      logic signed [7:0] temperature;
      logic              nack;
   } rsp_type;

   function automatic desc_type mk(kind_type k, logic c, logic d, step_type n, sel_type s);
      desc_type r;
      r.kind = k;
      r.scl  = c;
      r.sda  = d;
      r.nxt  = n;
      r.sel  = s;
      return r;
   endfunction

   // bus sequence program, one entry per step
   function automatic desc_type prog_desc(step_type s);
      desc_type r;
      case (s)
         // conversion: start, address+write, 0xEE
         5'd1:  r = mk(KIND_FIX, 1'b1, 1'b1, 5'd2,  SEL_ADDR_W);
         5'd2:  r = mk(KIND_FIX, 1'b1, 1'b0, 5'd3,  SEL_ADDR_W);
         5'd3:  r = mk(KIND_FIX, 1'b0, 1'b0, 5'd4,  SEL_ADDR_W);
         5'd4:  r = mk(KIND_WLO, 1'b0, 1'b0, 5'd5,  SEL_ADDR_W);
         5'd5:  r = mk(KIND_WHI, 1'b1, 1'b0, 5'd6,  SEL_ADDR_W);
         5'd6:  r = mk(KIND_WLO, 1'b0, 1'b0, 5'd7,  SEL_CONVERT);
         5'd7:  r = mk(KIND_WHI, 1'b1, 1'b0, 5'd25, SEL_ADDR_W);
         // read: start, address+write, 0xAA
         5'd8:  r = mk(KIND_FIX, 1'b1, 1'b1, 5'd9,  SEL_ADDR_W);
         5'd9:  r = mk(KIND_FIX, 1'b1, 1'b0, 5'd10, SEL_ADDR_W);
         5'd10: r = mk(KIND_FIX, 1'b0, 1'b0, 5'd11, SEL_ADDR_W);
         5'd11: r = mk(KIND_WLO, 1'b0, 1'b0, 5'd12, SEL_ADDR_W);
         5'd12: r = mk(KIND_WHI, 1'b1, 1'b0, 5'd13, SEL_ADDR_W);
         5'd13: r = mk(KIND_WLO, 1'b0, 1'b0, 5'd14, SEL_READ);
         5'd14: r = mk(KIND_WHI, 1'b1, 1'b0, 5'd15, SEL_ADDR_W);
         // repeated start
         5'd15: r = mk(KIND_FIX, 1'b0, 1'b1, 5'd16, SEL_ADDR_W);
         5'd16: r = mk(KIND_FIX, 1'b1, 1'b1, 5'd17, SEL_ADDR_W);
         5'd17: r = mk(KIND_FIX, 1'b1, 1'b0, 5'd18, SEL_ADDR_W);
         5'd18: r = mk(KIND_FIX, 1'b0, 1'b0, 5'd19, SEL_ADDR_W);
         // address+read, byte in, master nack
         5'd19: r = mk(KIND_WLO, 1'b0, 1'b0, 5'd20, SEL_ADDR_R);
         5'd20: r = mk(KIND_WHI, 1'b1, 1'b0, 5'd21, SEL_ADDR_W);
         5'd21: r = mk(KIND_RLO, 1'b0, 1'b1, 5'd22, SEL_ADDR_W);
         5'd22: r = mk(KIND_RHI, 1'b1, 1'b1, 5'd23, SEL_ADDR_W);
         5'd23: r = mk(KIND_FIX, 1'b0, 1'b1, 5'd24, SEL_ADDR_W);
         5'd24: r = mk(KIND_FIX, 1'b1, 1'b1, 5'd25, SEL_ADDR_W);
         // stop, shared by both commands
         5'd25: r = mk(KIND_FIX, 1'b0, 1'b0, 5'd26, SEL_ADDR_W);
         5'd26: r = mk(KIND_FIX, 1'b1, 1'b0, 5'd27, SEL_ADDR_W);
         5'd27: r = mk(KIND_FIX, 1'b1, 1'b1, 5'd0,  SEL_ADDR_W);
         default: r = mk(KIND_IDLE, 1'b1, 1'b1, 5'd0, SEL_ADDR_W);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] byte_for(sel_type sel, logic [6:0] addr);
      logic [7:0] r;
      case (sel)
         SEL_ADDR_W:  r = {addr, 1'b0};
         SEL_ADDR_R:  r = {addr, 1'b0} | BYTE_RD_FLAG;
         SEL_CONVERT: r = BYTE_CONVERT;
         default:     r = BYTE_READ;
      endcase
      return r;
   endfunction

   // shift register value on entry to a step
   function automatic logic [7:0] enter_shift(step_type n, logic [7:0] cur, logic [6:0] addr);
      desc_type   d;
      logic [7:0] r;
      d = prog_desc(n);
      if (d.kind == KIND_WLO) begin
         r = byte_for(d.sel, addr);
      end else if (d.kind == KIND_RLO) begin
         r = '0;
      end else begin
         r = cur;
      end
      return r;
   endfunction

endpackage

// ===== hdl/i2ctr_core.sv =====
// Bus sequencer of the temperature sensor reader: step, timers, shift byte, line levels.
// Depends on i2ctr_pkg and i2c_temp_sensor_reader_top_defines.svh.
`include "i2c_temp_sensor_reader_top_defines.svh"

module i2ctr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [1:0]          op,
   input  logic                sda_in,
   input  i2ctr_pkg::cfg_type  cfg,
   output i2ctr_pkg::rsp_type  res
);

   i2ctr_pkg::step_type step_ff, step_in;
   logic [3:0]          bits_ff, bits_in;
   logic [7:0]          phase_ff, phase_in;
   logic [7:0]          ack_ff, ack_in;
   logic [7:0]          shift_ff, shift_in;
   logic [7:0]          temp_ff, temp_in;
   logic                clk_ff, clk_in;
   logic                dat_ff, dat_in;
   logic                miss_ff, miss_in;
   logic                done;

   // one tick of the sequence
   always_comb begin
      i2ctr_pkg::desc_type d;
      i2ctr_pkg::step_type e_step;
      logic                start;
      logic [3:0]          e_bits;
      logic [7:0]          e_phase, e_ack, e_shift;
      logic [7:0]          hp, aw, pt1, ack1, rd_shift;
      logic                e_miss, ph_done, bit_out;

      start = (step_ff == i2ctr_pkg::STEP_IDLE) &&
              (op == i2ctr_pkg::OP_CONVERT || op == i2ctr_pkg::OP_READ);
      e_step  = start ? ((op == i2ctr_pkg::OP_CONVERT) ? i2ctr_pkg::STEP_CONVERT_BEGIN
                                                       : i2ctr_pkg::STEP_READ_BEGIN)
                      : step_ff;
      e_phase = start ? 8'd0 : phase_ff;
      e_ack   = start ? 8'd0 : ack_ff;
      e_bits  = start ? 4'd0 : bits_ff;
      e_shift = start ? i2ctr_pkg::enter_shift(e_step, shift_ff, cfg.dev_addr) : shift_ff;
      e_miss  = start ? 1'b0 : miss_ff;

      // zero timing registers act as one
      hp       = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
      aw       = (cfg.ack_wait == 8'd0) ? 8'd1 : cfg.ack_wait;
      pt1      = e_phase + 8'd1;
      ph_done  = (pt1 >= hp);
      ack1     = e_ack + 8'd1;
      bit_out  = (e_bits < i2ctr_pkg::BITS_PER_BYTE) ? e_shift[7] : 1'b1;
      rd_shift = {e_shift[6:0], sda_in};
      d        = i2ctr_pkg::prog_desc(e_step);

      step_in  = e_step;
      phase_in = e_phase;
      ack_in   = e_ack;
      bits_in  = e_bits;
      shift_in = e_shift;
      miss_in  = e_miss;
      temp_in  = temp_ff;
      clk_in   = clk_ff;
      dat_in   = dat_ff;
      done     = 1'b0;

      if (e_step != i2ctr_pkg::STEP_IDLE) begin
         unique case (d.kind)
            i2ctr_pkg::KIND_FIX: begin
               clk_in   = d.scl;
               dat_in   = d.sda;
               phase_in = pt1;
               if (ph_done) begin
                  step_in  = d.nxt;
                  phase_in = 8'd0;
                  ack_in   = 8'd0;
                  bits_in  = 4'd0;
                  shift_in = i2ctr_pkg::enter_shift(d.nxt, e_shift, cfg.dev_addr);
                  done     = (d.nxt == i2ctr_pkg::STEP_IDLE);
               end
            end
            i2ctr_pkg::KIND_WLO: begin
               clk_in   = 1'b0;
               dat_in   = bit_out;
               phase_in = pt1;
               if (ph_done) begin
                  step_in  = d.nxt;
                  phase_in = 8'd0;
               end
            end
            i2ctr_pkg::KIND_WHI: begin
               clk_in = 1'b1;
               dat_in = bit_out;
               if (e_bits < i2ctr_pkg::BITS_PER_BYTE) begin
                  // data bit high phase, then back to its low phase
                  phase_in = pt1;
                  if (ph_done) begin
                     shift_in = {e_shift[6:0], 1'b0};
                     bits_in  = e_bits + 4'd1;
                     step_in  = e_step - 5'd1;
                     phase_in = 8'd0;
                  end
               end else if (!sda_in || ack1 >= aw) begin
                  // ack seen or timed out
                  miss_in  = e_miss | sda_in;
                  step_in  = d.nxt;
                  phase_in = 8'd0;
                  ack_in   = 8'd0;
                  bits_in  = 4'd0;
                  shift_in = i2ctr_pkg::enter_shift(d.nxt, e_shift, cfg.dev_addr);
               end else begin
                  ack_in = ack1;
               end
            end
            i2ctr_pkg::KIND_RLO: begin
               clk_in   = 1'b0;
               dat_in   = 1'b1;
               phase_in = pt1;
               if (ph_done) begin
                  step_in  = d.nxt;
                  phase_in = 8'd0;
               end
            end
            i2ctr_pkg::KIND_RHI: begin
               clk_in   = 1'b1;
               dat_in   = 1'b1;
               phase_in = pt1;
               if (ph_done) begin
                  // sample on the last tick of the high phase
                  shift_in = rd_shift;
                  bits_in  = e_bits + 4'd1;
                  if (e_bits + 4'd1 >= i2ctr_pkg::BITS_PER_BYTE) begin
                     temp_in  = rd_shift;
                     step_in  = d.nxt;
                     phase_in = 8'd0;
                     ack_in   = 8'd0;
                     bits_in  = 4'd0;
                     shift_in = i2ctr_pkg::enter_shift(d.nxt, rd_shift, cfg.dev_addr);
                  end else begin
                     step_in  = e_step - 5'd1;
                     phase_in = 8'd0;
                  end
               end
            end
            default: begin
               step_in = i2ctr_pkg::STEP_IDLE;
               clk_in  = 1'b1;
               dat_in  = 1'b1;
            end
         endcase
      end
   end

   // result word of this tick
   always_comb begin
      res.scl         = clk_in;
      res.sda         = dat_in;
      res.busy        = (step_in != i2ctr_pkg::STEP_IDLE);
      res.done        = done;
      res.temperature = signed'(temp_in);
      res.nack        = miss_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= i2ctr_pkg::STEP_IDLE;
         bits_ff  <= '0;
         phase_ff <= '0;
         ack_ff   <= '0;
         shift_ff <= '0;
         temp_ff  <= '0;
         clk_ff   <= 1'b1;
         dat_ff   <= 1'b1;
         miss_ff  <= 1'b0;
      end else if (adv) begin
         step_ff  <= step_in;
         bits_ff  <= bits_in;
         phase_ff <= phase_in;
         ack_ff   <= ack_in;
         shift_ff <= shift_in;
         temp_ff  <= temp_in;
         clk_ff   <= clk_in;
         dat_ff   <= dat_in;
         miss_ff  <= miss_in;
      end
   end

   `I2CTR_ASSERT_RST(a_done_released, clock, reset, adv && res.done |-> !res.busy && res.scl && res.sda, "done without released idle bus")
   `I2CTR_ASSERT_RST(a_bits_range, clock, reset, bits_ff <= i2ctr_pkg::BITS_PER_BYTE, "bit count past one byte")
   `I2CTR_ASSERT_RST(a_hold_stall, clock, reset, !adv |=> $stable(step_ff) && $stable(miss_ff) && $stable(temp_ff), "state moved without a tick")
   `I2CTR_ASSERT(a_reset_idle, clock, reset |=> step_ff == i2ctr_pkg::STEP_IDLE && clk_ff && dat_ff, "reset left bus not idle")

endmodule

// ===== hdl/i2c_temp_sensor_reader_top.sv =====
// Top level of the temperature sensor reader: stream ports, input and result registers,
// configuration registers. Depends on i2ctr_pkg and i2ctr_core.
//
// Each request word is one bus timing tick and yields exactly one response word with the
// SCL/SDA levels to drive, busy/done flags, the last temperature byte and the nack flag.
// One word is taken every clock while rsp_tready is held. A word passes the input register,
// the sequencer logic and the result register. Its response is offered once the word has
// moved from the input register into the result register. While a response waits on
// rsp_tready the input register still takes one more word; then req_tready drops.
// A command (convert or read) is honored only when the sequencer is idle. Write the
// configuration registers only while no transaction is running.
module i2c_temp_sensor_reader_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // op[1:0], sda_in[2], zero[7:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                    // temperature[11:4], nack_seen[12], zero[15:13]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   logic               in_valid_ff;
   logic [1:0]         in_op_ff;
   logic               in_sda_ff;
   logic               out_valid_ff;
   i2ctr_pkg::rsp_type out_ff;
   i2ctr_pkg::rsp_type res;
   i2ctr_pkg::cfg_type cfg_ff;
   logic               adv;

   // a word moves on when the result register is free or draining
   assign adv        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.nack, out_ff.temperature, out_ff.done,
                        out_ff.busy, out_ff.sda, out_ff.scl};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (adv) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tdata[1:0];
         in_sda_ff <= req_tdata[2];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= res;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= i2ctr_pkg::HALF_PERIOD_RST;
         cfg_ff.ack_wait    <= i2ctr_pkg::ACK_WAIT_RST;
         cfg_ff.dev_addr    <= i2ctr_pkg::DEV_ADDR_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            i2ctr_pkg::CSR_HALF_PERIOD: cfg_ff.half_period <= csr_wdata;
            i2ctr_pkg::CSR_ACK_WAIT:    cfg_ff.ack_wait    <= csr_wdata;
            i2ctr_pkg::CSR_DEV_ADDR:    cfg_ff.dev_addr    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   i2ctr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .op     (in_op_ff),
      .sda_in (in_sda_ff),
      .cfg    (cfg_ff),
      .res    (res)
   );

endmodule
